[src/i2c_register_access_master_defines.svh]
// Assertion helpers for the I2C register access master.
`ifndef I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked outside reset.
`define I2CRAM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("i2cram check failed");
// Checked at every edge, reset included.
`define I2CRAM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("i2cram reset check failed");
`else
`define I2CRAM_ASSERT(lbl, prop)
`define I2CRAM_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[src/i2cram_pkg.sv]
package i2cram_pkg;

  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // transaction stage, one-hot
  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_START  = 8'b0000_0010,
    ST_ADDR   = 8'b0000_0100,
    ST_INDEX  = 8'b0000_1000,
    ST_VALUE  = 8'b0001_0000,  // value byte on a write, repeated start on a read
    ST_RADDR  = 8'b0010_0000,
    ST_BYTEIN = 8'b0100_0000,
    ST_STOP   = 8'b1000_0000
  } stage_t;

  typedef struct packed {
    stage_t      stage;
    logic [5:0]  phase;   // tick within the stage
    logic [1:0]  sub;     // position within a bit of an outgoing byte
    logic        is_read;
    logic [7:0]  shift;
    logic [6:0]  addr;
    logic [7:0]  index;
    logic [7:0]  value;
    logic        ack;
    logic        scl;
    logic        sda;
  } state_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic       ack;
    logic [7:0] rdata;
  } result_t;

endpackage

[src/i2cram_step.sv]
module i2cram_step (
  input  i2cram_pkg::state_t  st,
  input  logic [1:0]          op,
  input  logic [6:0]          device_addr,
  input  logic [7:0]          reg_index,
  input  logic [7:0]          write_value,
  input  logic                sda_in,
  output i2cram_pkg::state_t  st_next,
  output i2cram_pkg::result_t res
);
  import i2cram_pkg::*;

  always_comb begin
    state_t cur;
    state_t nxt;
    logic   fin;
    logic   done;
    stage_t enter;

    cur   = st;
    fin   = 1'b0;
    done  = 1'b0;
    enter = ST_IDLE;

    // new request only from idle; its first phase runs this same tick
    if (cur.stage == ST_IDLE && (op inside {OP_WRITE, OP_READ})) begin
      cur.addr    = device_addr;
      cur.index   = reg_index;
      cur.value   = write_value;
      cur.is_read = (op == OP_READ);
      cur.ack     = 1'b1;
      cur.shift   = 8'd0;
      cur.stage   = ST_START;
      cur.phase   = 6'd0;
      cur.sub     = 2'd0;
    end

    nxt = cur;

    case (cur.stage)
      ST_IDLE: begin
      end
      ST_START, ST_STOP: begin
        // start: scl hi, sda lo, scl lo, sda rel; stop: scl lo, sda lo, scl hi, sda rel
        case (cur.phase)
          6'd0: nxt.scl = (cur.stage == ST_START);
          6'd1: nxt.sda = 1'b0;
          6'd2: nxt.scl = (cur.stage == ST_STOP);
          default: begin
            nxt.sda = 1'b1;
            fin     = 1'b1;
          end
        endcase
      end
      ST_BYTEIN: begin
        if (cur.phase < 6'd16) begin
          if (!cur.phase[0]) begin
            nxt.scl   = 1'b1;
            nxt.shift = {cur.shift[6:0], sda_in};
          end else begin
            nxt.scl = 1'b0;
          end
        end else if (cur.phase == 6'd16) begin
          nxt.scl = 1'b1;
        end else if (cur.phase == 6'd17) begin
          nxt.scl = 1'b0;
        end else begin
          nxt.sda = 1'b1;
          fin     = 1'b1;
        end
      end
      ST_ADDR, ST_INDEX, ST_VALUE, ST_RADDR: begin
        if (cur.stage == ST_VALUE && cur.is_read) begin
          // repeated start
          case (cur.phase)
            6'd0: nxt.scl = 1'b1;
            6'd1: nxt.sda = 1'b0;
            6'd2: nxt.scl = 1'b0;
            default: begin
              nxt.sda = 1'b1;
              fin     = 1'b1;
            end
          endcase
        end else if (cur.phase < 6'd24) begin
          case (cur.sub)
            2'd0: nxt.sda = cur.shift[7];
            2'd1: nxt.scl = 1'b1;
            default: begin
              nxt.scl   = 1'b0;
              nxt.shift = {cur.shift[6:0], 1'b0};
            end
          endcase
          nxt.sub = (cur.sub == 2'd2) ? 2'd0 : cur.sub + 2'd1;
        end else if (cur.phase == 6'd24) begin
          nxt.sda = 1'b1;
        end else if (cur.phase == 6'd25) begin
          nxt.scl = 1'b1;
          // write reports the value byte alone
          nxt.ack = (cur.stage == ST_VALUE) ? !sda_in : (cur.ack & !sda_in);
        end else begin
          nxt.scl = 1'b0;
          fin     = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (cur.stage != ST_IDLE) begin
      if (fin) begin
        case (cur.stage)
          ST_START:  enter = ST_ADDR;
          ST_ADDR:   enter = ST_INDEX;
          ST_INDEX:  enter = ST_VALUE;
          ST_VALUE:  enter = cur.is_read ? ST_RADDR : ST_STOP;
          ST_RADDR:  enter = ST_BYTEIN;
          ST_BYTEIN: enter = ST_STOP;
          default:   enter = ST_IDLE;
        endcase
        done      = (enter == ST_IDLE);
        nxt.stage = enter;
        nxt.phase = 6'd0;
        nxt.sub   = 2'd0;
        case (enter)
          ST_ADDR:   nxt.shift = {cur.addr, 1'b0};
          ST_INDEX:  nxt.shift = cur.index;
          ST_VALUE:  nxt.shift = cur.is_read ? nxt.shift : cur.value;
          ST_RADDR:  nxt.shift = {cur.addr, 1'b1};
          ST_BYTEIN: nxt.shift = 8'd0;
          default:   nxt.shift = nxt.shift;
        endcase
      end else begin
        nxt.phase = cur.phase + 6'd1;
      end
    end

    st_next   = nxt;
    res.scl   = nxt.scl;
    res.sda   = nxt.sda;
    res.busy  = (nxt.stage != ST_IDLE);
    res.done  = done;
    res.ack   = done & nxt.ack;
    res.rdata = (done && nxt.is_read) ? nxt.shift : 8'd0;
  end

endmodule

[src/i2c_register_access_master.sv]
// I2C master for single-register write and read transactions.
// Input channel (in_valid/in_stall): one item per pin-phase tick. op 1 starts
// a register write, op 2 a register read; both only while idle, otherwise the
// op is ignored. device_addr, reg_index and write_value are latched at start.
// sda_in is the sampled SDA line, used on the ticks that raise SCL.
// Output channel (out_valid/out_stall): one item per input item, carrying the
// SCL/SDA levels after that tick, busy_res, done_res on the tick that ends the
// stop condition, ack_ok and read_value (both valid with done_res only).
// A write is 89 ticks long, a read 112.
// An item's result is registered in the output register, or in the skid one.
// Throughput: one item per cycle while in_stall is low; the whole tick update
// is a single pass of combinational logic from the bus state register.
// Stall: a result held by out_stall parks in a skid register so one more
// item is still taken; in_stall rises only while the skid register is full.
// Reset: bus state idle, SCL and SDA released high; both output slots empty.
module i2c_register_access_master (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [6:0] device_addr,
  input  logic [7:0] reg_index,
  input  logic [7:0] write_value,
  input  logic       sda_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl_out,
  output logic       sda_out,
  output logic       busy_res,
  output logic       done_res,
  output logic       ack_ok,
  output logic [7:0] read_value
);
  import i2cram_pkg::*;

  `include "i2c_register_access_master_defines.svh"

  state_t  st;
  state_t  st_next;
  result_t res;
  result_t out_q;
  result_t skid_q;
  logic    skid_valid;
  logic    accept;
  logic    slot_free;

  // bus state update for one tick
  i2cram_step u_step (
    .st          (st),
    .op          (op),
    .device_addr (device_addr),
    .reg_index   (reg_index),
    .write_value (write_value),
    .sda_in      (sda_in),
    .st_next     (st_next),
    .res         (res)
  );

  assign in_stall  = skid_valid;
  assign accept    = in_valid && !skid_valid;
  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{stage: ST_IDLE, phase: 6'd0, sub: 2'd0, is_read: 1'b0, shift: 8'd0,
              addr: 7'd0, index: 8'd0, value: 8'd0, ack: 1'b1, scl: 1'b1, sda: 1'b1};
    end else if (accept) begin
      st <= st_next;
    end
  end

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (slot_free) begin
        out_q      <= skid_q;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (slot_free) begin
        out_q     <= res;
        out_valid <= 1'b1;
      end else begin
        skid_q     <= res;
        skid_valid <= 1'b1;
      end
    end else if (slot_free) begin
      out_valid <= 1'b0;
    end
  end

  assign scl_out    = out_q.scl;
  assign sda_out    = out_q.sda;
  assign busy_res   = out_q.busy;
  assign done_res   = out_q.done;
  assign ack_ok     = out_q.ack;
  assign read_value = out_q.rdata;

  // skid register only fills behind a held output
  `I2CRAM_ASSERT(a_skid_behind_out, skid_valid |-> out_valid)
  // a finished transaction is no longer busy
  `I2CRAM_ASSERT(a_done_not_busy, (out_valid && done_res) |-> !busy_res)
  // read data and ack only show with done
  `I2CRAM_ASSERT(a_res_only_on_done,
    (out_valid && !done_res) |-> (read_value == 8'd0 && !ack_ok))
  // an idle bus has both lines released
  `I2CRAM_ASSERT(a_idle_released, (st.stage == ST_IDLE) |-> (st.scl && st.sda))
  // reset empties both slots
  `I2CRAM_ASSERT_ALWAYS(a_reset_empty, rst |=> (!out_valid && !skid_valid))

endmodule
